[sv/lcct_pkg.sv]
// shared types and constants for the lru chunk cache tracker
`default_nettype none

package lcct_pkg;

    localparam int CACHE_ENTRIES_DEF = 8;
    localparam int ID_W              = 24;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_CMP  = 3'b010,
        ST_UPD  = 3'b100
    } lcct_state_t;

    typedef struct packed {
        logic load;
        logic compare;
        logic update;
    } lcct_cmd_t;

    typedef struct packed {
        logic out_busy;
    } lcct_status_t;

endpackage

`default_nettype wire

[sv/lcct_ifs.sv]
// request and response channel interfaces
`default_nettype none

interface lcct_req_if;
    logic                       valid;
    logic                       ready;
    logic [lcct_pkg::ID_W-1:0]  chunk_id;

    modport source (output valid, output chunk_id, input ready);
    modport sink   (input valid, input chunk_id, output ready);
endinterface

interface lcct_rsp_if;
    logic                       valid;
    logic                       ready;
    logic                       hit;
    logic                       victim_valid;
    logic [lcct_pkg::ID_W-1:0]  victim_id;

    modport source (output valid, output hit, output victim_valid, output victim_id,
                    input ready);
    modport sink   (input valid, input hit, input victim_valid, input victim_id,
                    output ready);
endinterface

`default_nettype wire

[sv/lcct_ctrl.sv]
// controller state machine sequencing load, compare and update
`default_nettype none

module lcct_ctrl (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  req_valid,
    output logic                       req_ready,
    input  wire lcct_pkg::lcct_status_t status,
    output lcct_pkg::lcct_cmd_t         cmd
);

    lcct_pkg::lcct_state_t state_reg;
    lcct_pkg::lcct_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= lcct_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        req_ready   = 1'b0;
        cmd         = '0;
        case (state_reg)
            lcct_pkg::ST_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = lcct_pkg::ST_CMP;
                end
            end
            lcct_pkg::ST_CMP:
            begin
                cmd.compare = 1'b1;
                state_next  = lcct_pkg::ST_UPD;
            end
            lcct_pkg::ST_UPD:
            begin
                if (!status.out_busy)
                begin
                    cmd.update = 1'b1;
                    state_next = lcct_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = lcct_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

[sv/lcct_dp.sv]
// datapath: recency list, match vector, fill count and result register
`default_nettype none

module lcct_dp #(
    parameter int CACHE_ENTRIES = lcct_pkg::CACHE_ENTRIES_DEF
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire lcct_pkg::lcct_cmd_t          cmd,
    output lcct_pkg::lcct_status_t            status,
    output logic [$clog2(CACHE_ENTRIES+1)-1:0] held,
    input  wire logic [lcct_pkg::ID_W-1:0]    req_chunk_id,
    output logic                              rsp_valid,
    input  wire logic                         rsp_ready,
    output logic                              rsp_hit,
    output logic                              rsp_victim_valid,
    output logic [lcct_pkg::ID_W-1:0]         rsp_victim_id
);

    localparam int CNT_W = $clog2(CACHE_ENTRIES + 1);
    localparam logic [CNT_W-1:0] FULL = CNT_W'(CACHE_ENTRIES);

    logic [lcct_pkg::ID_W-1:0] entry_reg [CACHE_ENTRIES];
    logic [lcct_pkg::ID_W-1:0] id_reg;
    logic [CACHE_ENTRIES-1:0]  match_reg;
    logic [CNT_W-1:0]          held_reg;
    logic [CNT_W-1:0]          held_next;
    logic                      out_valid_reg;
    logic                      hit_reg;
    logic                      vvalid_reg;
    logic [lcct_pkg::ID_W-1:0] vid_reg;

    logic                      any_match;
    logic                      full;
    logic [CACHE_ENTRIES-1:0]  lowest;
    logic [CACHE_ENTRIES-1:0]  shift_en;

    // positions up to and including the first match move one place older; on a miss all filled positions do
    always_comb
    begin
        any_match = |match_reg;
        full      = (held_reg == FULL);
        lowest    = match_reg & (~match_reg + CACHE_ENTRIES'(1));
        for (int k = 0; k < CACHE_ENTRIES; k++)
        begin
            shift_en[k] = (CNT_W'(k) <= held_reg);
        end
        if (any_match)
        begin
            shift_en = lowest | (lowest - CACHE_ENTRIES'(1));
        end
        held_next = held_reg;
        if (!any_match && !full)
        begin
            held_next = held_reg + CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            id_reg <= req_chunk_id;
        end
        if (cmd.compare)
        begin
            for (int k = 0; k < CACHE_ENTRIES; k++)
            begin
                match_reg[k] <= (entry_reg[k] == id_reg) && (CNT_W'(k) < held_reg);
            end
        end
        if (cmd.update)
        begin
            entry_reg[0] <= id_reg;
            for (int k = 1; k < CACHE_ENTRIES; k++)
            begin
                if (shift_en[k])
                begin
                    entry_reg[k] <= entry_reg[k-1];
                end
            end
            hit_reg    <= any_match;
            vvalid_reg <= !any_match && full;
            vid_reg    <= (!any_match && full) ? entry_reg[CACHE_ENTRIES-1] : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.update)
            begin
                held_reg      <= held_next;
                out_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign status.out_busy  = out_valid_reg && !rsp_ready;
    assign held             = held_reg;
    assign rsp_valid        = out_valid_reg;
    assign rsp_hit          = hit_reg;
    assign rsp_victim_valid = vvalid_reg;
    assign rsp_victim_id    = vid_reg;

endmodule

`default_nettype wire

[sv/lru_chunk_cache_tracker.sv]
// top level of the fully associative lru chunk cache tracker
//
//  channel  dir  payload                              handshake
//  req      in   chunk_id[23:0]                       valid / ready
//  rsp      out  hit, victim_valid, victim_id[23:0]   valid / ready
//
//  each item passes three steps: accept, parallel compare of all entries, update
//  the compare stage registers a match vector; the update stage shifts the list
//  one result per item; the next item is accepted while a result waits
//  the update waits while the result register is still held by a stalled sink
//  reset empties the store (fill count to zero); list entries are not cleared
`default_nettype none

module lru_chunk_cache_tracker #(
    parameter int CACHE_ENTRIES = lcct_pkg::CACHE_ENTRIES_DEF
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    lcct_req_if.sink    req,
    lcct_rsp_if.source  rsp
);

    lcct_pkg::lcct_cmd_t    cmd;
    lcct_pkg::lcct_status_t status;
    logic [$clog2(CACHE_ENTRIES+1)-1:0] held;

    lcct_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .status    (status),
        .cmd       (cmd)
    );

    lcct_dp #(
        .CACHE_ENTRIES (CACHE_ENTRIES)
    ) u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .status           (status),
        .held             (held),
        .req_chunk_id     (req.chunk_id),
        .rsp_valid        (rsp.valid),
        .rsp_ready        (rsp.ready),
        .rsp_hit          (rsp.hit),
        .rsp_victim_valid (rsp.victim_valid),
        .rsp_victim_id    (rsp.victim_id)
    );

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.update |-> !(rsp.valid && !rsp.ready))
        else $error("result register overwritten");

    a_hit_no_victim: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.hit) |-> !rsp.victim_valid)
        else $error("hit reported with a victim");

    a_victim_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && !rsp.victim_valid) |-> (rsp.victim_id == '0))
        else $error("victim id not zero without eviction");

    a_held_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(held) <= CACHE_ENTRIES)
        else $error("fill count beyond capacity");

    a_victim_full: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.update ##1 (rsp.victim_valid)) |-> (32'(held) == CACHE_ENTRIES))
        else $error("eviction while store not full");

endmodule

`default_nettype wire
